// ----- hdl/b64d_pkg.sv -----
package b64d_pkg;

	// One completed group on its way from the front end to the byte emitter.
	typedef struct packed {
		logic [23:0] word;
		logic [1:0]  nbytes;
	} group_t;

	// Queue status as seen by the two sides.
	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	// Bytes in a full group.
	localparam logic [1:0] GROUP_BYTES = 2'd3;

endpackage

// ----- hdl/b64d_text_if.sv -----
interface b64d_text_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_char;
	logic       flush;

	modport source (output valid, output in_char, output flush, input ready);
	modport sink (input valid, input in_char, input flush, output ready);
endinterface

// ----- hdl/b64d_data_if.sv -----
interface b64d_data_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       last_of_run;

	modport source (output valid, output out_byte, output last_of_run, input ready);
	modport sink (input valid, input out_byte, input last_of_run, output ready);
endinterface

// ----- hdl/base64_stream_decoder.sv -----
// Base64 decoder: one character request per cycle, up to three bytes per group.
// Throughput: one character accepted and one byte delivered per cycle while the
// receiver is ready; the input stalls only when the group queue between front
// end and emitter is full. Groups pass through the queue, the current-group
// register and the output register. Reset (arst_n low, asynchronous) empties
// the queue and the output register and clears the partial group.
module base64_stream_decoder #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	b64d_text_if.sink    text,
	b64d_data_if.source  data
);
	import b64d_pkg::*;

	q_status_t q_status;
	group_t    push_group;
	group_t    head;
	logic      push;
	logic      pop;

	b64d_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.text       (text),
		.q_status   (q_status),
		.push       (push),
		.push_group (push_group)
	);

	b64d_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_group (push_group),
		.pop        (pop),
		.head       (head),
		.status     (q_status)
	);

	b64d_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.data     (data),
		.q_status (q_status),
		.head     (head),
		.pop      (pop)
	);

endmodule

// ----- hdl/b64d_front.sv -----
module b64d_front (
	input  logic              clk,
	input  logic              arst_n,
	b64d_text_if.sink         text,
	input  b64d_pkg::q_status_t q_status,
	output logic              push,
	output b64d_pkg::group_t  push_group
);
	import b64d_pkg::*;

	typedef enum logic [1:0] {
		CLS_DATA,
		CLS_PAD,
		CLS_SKIP
	} char_class_t;

	localparam logic [7:0] CHAR_PLUS  = 8'h2b;
	localparam logic [7:0] CHAR_SLASH = 8'h2f;
	localparam logic [7:0] CHAR_EQ    = 8'h3d;
	localparam logic [7:0] CHAR_0     = 8'h30;
	localparam logic [7:0] CHAR_9     = 8'h39;
	localparam logic [7:0] CHAR_UA    = 8'h41;
	localparam logic [7:0] CHAR_UZ    = 8'h5a;
	localparam logic [7:0] CHAR_LA    = 8'h61;
	localparam logic [7:0] CHAR_LZ    = 8'h7a;
	localparam logic [5:0] SEXTET_PLUS  = 6'd62;
	localparam logic [5:0] SEXTET_SLASH = 6'd63;
	localparam logic [5:0] SEXTET_DIGIT = 6'd52;
	localparam logic [5:0] SEXTET_LOWER = 6'd26;

	// Group being gathered: up to three sextets, right aligned.
	logic [17:0] acc_q;
	logic [1:0]  fill_q;
	logic [1:0]  pad_q;

	char_class_t cls;
	logic [5:0]  sextet;
	logic        accept;
	logic        grp_done;
	logic [23:0] grp_word;
	logic [1:0]  grp_pads;
	logic [1:0]  pad_next;
	logic [2:0]  missing;
	logic [2:0]  pad_sum;
	logic [7:0]  c;

	assign c = text.in_char;
	assign text.ready = !q_status.full;
	assign accept = text.valid && text.ready;

	// Character classification into sextet, pad or skip.
	always_comb begin
		cls = CLS_SKIP;
		sextet = '0;
		if (c == CHAR_PLUS) begin
			cls = CLS_DATA;
			sextet = SEXTET_PLUS;
		end else if (c == CHAR_SLASH) begin
			cls = CLS_DATA;
			sextet = SEXTET_SLASH;
		end else if (c == CHAR_EQ) begin
			cls = CLS_PAD;
		end else if (c >= CHAR_0 && c <= CHAR_9) begin
			cls = CLS_DATA;
			sextet = 6'(c - CHAR_0) + SEXTET_DIGIT;
		end else if (c >= CHAR_UA && c <= CHAR_UZ) begin
			cls = CLS_DATA;
			sextet = 6'(c - CHAR_UA);
		end else if (c >= CHAR_LA && c <= CHAR_LZ) begin
			cls = CLS_DATA;
			sextet = 6'(c - CHAR_LA) + SEXTET_LOWER;
		end
	end

	// Group completion, either by a fourth sextet or by a flush.
	always_comb begin
		grp_done = 1'b0;
		grp_word = {6'd0, acc_q};
		grp_pads = pad_q;
		pad_next = pad_q;
		missing = 3'd4 - {1'b0, fill_q};
		pad_sum = {1'b0, pad_q} + missing;
		if (cls == CLS_PAD && pad_q != 2'd3) begin
			pad_next = pad_q + 2'd1;
		end
		if (text.flush) begin
			grp_done = (fill_q != 2'd0);
			grp_pads = (pad_sum > 3'd3) ? 2'd3 : pad_sum[1:0];
			case (fill_q)
				2'd1:    grp_word = {acc_q[5:0], 18'd0};
				2'd2:    grp_word = {acc_q[11:0], 12'd0};
				2'd3:    grp_word = {acc_q, 6'd0};
				default: grp_word = '0;
			endcase
		end else if (cls != CLS_SKIP) begin
			grp_done = (fill_q == 2'd3);
			grp_pads = pad_next;
			grp_word = {acc_q, sextet};
		end
	end

	// A group that yields no bytes is dropped here.
	assign push_group.word = grp_word;
	assign push_group.nbytes = (grp_pads == 2'd3) ? 2'd0 : GROUP_BYTES - grp_pads;
	assign push = accept && grp_done && (grp_pads != 2'd3);

	// Accumulator state update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			fill_q <= '0;
			pad_q <= '0;
		end else if (accept) begin
			if (grp_done) begin
				acc_q <= '0;
				fill_q <= '0;
				pad_q <= '0;
			end else if (!text.flush && cls != CLS_SKIP) begin
				acc_q <= grp_word[17:0];
				fill_q <= fill_q + 2'd1;
				pad_q <= pad_next;
			end
		end
	end

endmodule

// ----- hdl/b64d_queue.sv -----
module b64d_queue #(
	parameter int DEPTH = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  b64d_pkg::group_t    push_group,
	input  logic                pop,
	output b64d_pkg::group_t    head,
	output b64d_pkg::q_status_t status
);
	import b64d_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	group_t          mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_push;
	logic            do_pop;

	assign status.full = (count_q == CW'(DEPTH));
	assign status.empty = (count_q == '0);
	assign do_push = push && !status.full;
	assign do_pop = pop && !status.empty;
	assign head = mem_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_group;
		end
	end

	// Pointers and occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

// ----- hdl/b64d_back.sv -----
module b64d_back (
	input  logic                clk,
	input  logic                arst_n,
	b64d_data_if.source         data,
	input  b64d_pkg::q_status_t q_status,
	input  b64d_pkg::group_t    head,
	output logic                pop
);
	import b64d_pkg::*;

	// Group being emitted and the index of its next byte.
	logic [23:0] cur_word_q;
	logic [1:0]  cur_n_q;
	logic [1:0]  cur_k_q;
	logic        cur_valid_q;

	// Output register.
	logic        out_valid_q;
	logic [7:0]  out_byte_q;
	logic        out_last_q;

	logic        load_out;
	logic        cur_last;
	logic        cur_free;
	logic [7:0]  cur_byte;

	assign load_out = !out_valid_q || data.ready;
	assign cur_last = (cur_k_q == cur_n_q - 2'd1);
	assign cur_free = !cur_valid_q || (load_out && cur_last);
	assign pop = cur_free && !q_status.empty;

	// Byte selection, most significant first.
	always_comb begin
		case (cur_k_q)
			2'd0:    cur_byte = cur_word_q[23:16];
			2'd1:    cur_byte = cur_word_q[15:8];
			2'd2:    cur_byte = cur_word_q[7:0];
			default: cur_byte = '0;
		endcase
	end

	// Current group tracking.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			cur_k_q <= '0;
			cur_n_q <= '0;
		end else if (cur_free) begin
			cur_valid_q <= !q_status.empty;
			cur_k_q <= '0;
			cur_n_q <= head.nbytes;
		end else if (load_out) begin
			cur_k_q <= cur_k_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cur_free) begin
			cur_word_q <= head.word;
		end
	end

	// Output register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= cur_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_byte_q <= cur_byte;
			out_last_q <= cur_last;
		end
	end

	assign data.valid = out_valid_q;
	assign data.out_byte = out_byte_q;
	assign data.last_of_run = out_last_q;

endmodule

// ----- hdl/b64d_checker.sv -----
module b64d_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       data_valid,
	input logic       data_ready,
	input logic [7:0] data_byte,
	input logic       data_last
);

	// The output register is empty while reset is asserted.
	a_reset_empty: assert property (@(posedge clk) !arst_n |-> !data_valid)
		else $error("output valid during reset");

	// The bytes of one group leave back to back.
	a_group_gapless: assert property (@(posedge clk) disable iff (!arst_n)
		data_valid && data_ready && !data_last |=> data_valid)
		else $error("gap inside a group");

	// A stalled byte is held.
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		data_valid && !data_ready |=> data_valid)
		else $error("valid dropped while stalled");

	a_hold_payload: assert property (@(posedge clk) disable iff (!arst_n)
		data_valid && !data_ready |=> $stable(data_byte) && $stable(data_last))
		else $error("payload changed while stalled");

endmodule

bind base64_stream_decoder b64d_checker u_b64d_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.data_valid (data.valid),
	.data_ready (data.ready),
	.data_byte  (data.out_byte),
	.data_last  (data.last_of_run)
);

// ----- dv/b64d_decode_checker.sv -----
`timescale 1ns / 100ps

// Watches the character and byte channels of the base64 decoder, predicts
// the decoded bytes of every accepted request and compares them in order.
module b64d_decode_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       text_valid,
	input  logic       text_ready,
	input  logic [7:0] in_char,
	input  logic       flush,
	input  logic       data_valid,
	input  logic       data_ready,
	input  logic [7:0] out_byte,
	input  logic       last_of_run,
	output int         fail_count,
	output int         bytes_checked,
	output int         bytes_pending
);

	// Character classes: 0..63 are sextets, the two above are pad and skip.
	localparam logic [6:0] SEXTET_PLUS  = 7'd62;
	localparam logic [6:0] SEXTET_SLASH = 7'd63;
	localparam logic [6:0] DIGIT_BASE   = 7'd52;
	localparam logic [6:0] LOWER_BASE   = 7'd26;
	localparam logic [6:0] CLASS_PAD    = 7'd64;
	localparam logic [6:0] CLASS_SKIP   = 7'd65;
	localparam bit   [1:0] MAX_PADS     = 2'd3;
	localparam bit   [1:0] LAST_SEXTET  = 2'd3;

	typedef struct packed {
		logic [7:0] value;
		logic       last;
	} decoded_byte_t;

	// Bytes predicted but not yet seen on the data channel, oldest first.
	decoded_byte_t decoded_q[$];

	// Partial group as the decoder should hold it.
	bit [23:0] gathered_bits;
	bit [1:0]  sextets_held;
	bit [1:0]  pads_held;

	function automatic logic [6:0] classify_char(input logic [7:0] ch);
		if (ch == "+") return SEXTET_PLUS;
		if (ch == "/") return SEXTET_SLASH;
		if (ch == "=") return CLASS_PAD;
		if (ch >= "0" && ch <= "9") return DIGIT_BASE + 7'(ch - "0");
		if (ch >= "A" && ch <= "Z") return 7'(ch - "A");
		if (ch >= "a" && ch <= "z") return LOWER_BASE + 7'(ch - "a");
		return CLASS_SKIP;
	endfunction

	// Queues the group's bytes, less one per pad, and starts a new group.
	task automatic close_group(input bit [23:0] word, input bit [1:0] pads);
		int nbytes;
		decoded_byte_t b;
		nbytes = (pads == MAX_PADS) ? 0 : int'(b64d_pkg::GROUP_BYTES) - int'(pads);
		for (int k = 0; k < nbytes; k++) begin
			b.value = word[16 - 8 * k +: 8];
			b.last = (k + 1 == nbytes);
			decoded_q.push_back(b);
		end
		gathered_bits = '0;
		sextets_held = '0;
		pads_held = '0;
	endtask

	task automatic predict_bytes(input logic [7:0] ch, input logic fl);
		logic [6:0] cls;
		bit [23:0] word;
		int missing;
		int pads;
		// A flush pads out a partial group; an empty group is left alone.
		if (fl) begin
			if (sextets_held == 0) return;
			missing = 4 - int'(sextets_held);
			word = gathered_bits << (6 * missing);
			pads = int'(pads_held) + missing;
			if (pads > int'(MAX_PADS)) pads = int'(MAX_PADS);
			close_group(word, 2'(pads));
			return;
		end
		cls = classify_char(ch);
		if (cls == CLASS_SKIP) return;
		// A pad counts as sextet zero; the pad count saturates.
		if (cls == CLASS_PAD) begin
			if (pads_held != MAX_PADS) pads_held++;
			cls = '0;
		end
		word = {gathered_bits[17:0], cls[5:0]};
		if (sextets_held == LAST_SEXTET) begin
			close_group(word, pads_held);
		end else begin
			gathered_bits = word;
			sextets_held++;
		end
	endtask

	task automatic check_byte();
		decoded_byte_t want;
		if (decoded_q.size() == 0) begin
			fail_count++;
			$error("out_byte: expected nothing, got %h", out_byte);
			return;
		end
		want = decoded_q.pop_front();
		bytes_checked++;
		if (out_byte !== want.value) begin
			fail_count++;
			$error("out_byte: expected %h, got %h", want.value, out_byte);
		end
		if (last_of_run !== want.last) begin
			fail_count++;
			$error("last_of_run: expected %b, got %b", want.last, last_of_run);
		end
	endtask

	// Outputs are checked before the same edge's request is predicted, since a
	// byte can never leave in the cycle its request is taken.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decoded_q.delete();
			gathered_bits = '0;
			sextets_held = '0;
			pads_held = '0;
			bytes_pending = 0;
		end else begin
			if (data_valid && data_ready) check_byte();
			if (text_valid && text_ready) predict_bytes(in_char, flush);
			bytes_pending = decoded_q.size();
		end
	end

endmodule

// ----- dv/tb_base64_stream_decoder.sv -----
`timescale 1ns / 100ps

module tb_base64_stream_decoder;

	typedef enum {SINK_FREE, SINK_COIN, SINK_QUARTER, SINK_TRICKLE} sink_mode_t;

	logic clk;
	logic arst_n;

	b64d_text_if text_ch();
	b64d_data_if data_ch();

	int fail_count;
	int bytes_checked;
	int bytes_pending;
	int requests_sent;
	int flushes_sent;
	int fillers_sent;
	int burst_left;

	base64_stream_decoder dut (
		.clk    (clk),
		.arst_n (arst_n),
		.text   (text_ch.sink),
		.data   (data_ch.source)
	);

	b64d_decode_checker decode_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.text_valid    (text_ch.valid),
		.text_ready    (text_ch.ready),
		.in_char       (text_ch.in_char),
		.flush         (text_ch.flush),
		.data_valid    (data_ch.valid),
		.data_ready    (data_ch.ready),
		.out_byte      (data_ch.out_byte),
		.last_of_run   (data_ch.last_of_run),
		.fail_count    (fail_count),
		.bytes_checked (bytes_checked),
		.bytes_pending (bytes_pending)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Hard stop in case the decoder hangs.
	initial begin
		#2_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	// Encodes a sextet as its alphabet character.
	function automatic logic [7:0] sextet_char(input logic [5:0] s);
		if (s < 6'd26) return "A" + 8'(s);
		if (s < 6'd52) return "a" + 8'(s - 6'd26);
		if (s < 6'd62) return "0" + 8'(s - 6'd52);
		if (s == 6'd62) return "+";
		return "/";
	endfunction

	// Picks a byte outside the alphabet and the pad.
	function automatic logic [7:0] filler_char();
		case ($urandom_range(0, 4))
			0: return 8'($urandom_range(8'h80, 8'hFF));
			1: return 8'($urandom_range(8'h00, 8'h2A));
			2: return 8'($urandom_range(8'h5B, 8'h60));
			3: return 8'($urandom_range(8'h7B, 8'h7F));
			default: return 8'($urandom_range(8'h3A, 8'h3C));
		endcase
	endfunction

	// Sends one request; the sender idles for a random gap between bursts.
	task automatic send_text(input logic [7:0] ch, input logic fl);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				@(negedge clk);
				text_ch.valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		text_ch.valid <= 1'b1;
		text_ch.in_char <= ch;
		text_ch.flush <= fl;
		@(posedge clk);
		while (!text_ch.ready) @(posedge clk);
		requests_sent++;
		if (fl) flushes_sent++;
	endtask

	task automatic send_string(input string s);
		for (int i = 0; i < s.len(); i++) send_text(s[i], 1'b0);
	endtask

	task automatic send_filler();
		send_text(filler_char(), 1'b0);
		fillers_sent++;
	endtask

	// The receiver switches among randomly chosen stall patterns.
	initial begin : receiver
		sink_mode_t mode;
		int tick;
		data_ch.ready = 1'b0;
		mode = SINK_FREE;
		tick = 0;
		forever begin
			@(negedge clk);
			if (tick % 48 == 0) mode = sink_mode_t'($urandom_range(0, 3));
			tick++;
			case (mode)
				SINK_FREE: data_ch.ready <= 1'b1;
				SINK_COIN: data_ch.ready <= 1'($urandom_range(0, 1));
				SINK_QUARTER: data_ch.ready <= (tick % 4 == 0);
				default: data_ch.ready <= ($urandom_range(0, 7) == 0);
			endcase
		end
	end

	initial begin : stimulus
		int pads;
		int count;
		arst_n = 1'b0;
		text_ch.valid = 1'b0;
		text_ch.in_char = 8'h00;
		text_ch.flush = 1'b0;
		requests_sent = 0;
		flushes_sent = 0;
		fillers_sent = 0;
		burst_left = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Alphabet edges, both pad counts, a pad ahead of data and pad saturation.
		send_string("AZaz09+/");
		send_string("QQ==");
		send_string("=QUJ");
		send_string("====");
		// Bytes outside the alphabet, including all zeros and all ones.
		send_text(8'h00, 1'b0);
		send_text(8'hFF, 1'b0);
		// Flushes of an empty group, a single sextet and two sextets.
		send_text("A", 1'b1);
		send_string("Q");
		send_text(8'h00, 1'b1);
		send_string("QU");
		send_text(8'hFF, 1'b1);

		// Mostly well-formed groups with random content, plus broken sequences.
		while (requests_sent < 430) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5: begin
					pads = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
					for (int i = 0; i < 4; i++) begin
						if ($urandom_range(0, 5) == 0) send_filler();
						if (i >= 4 - pads) send_text("=", 1'b0);
						else send_text(sextet_char(6'($urandom)), 1'b0);
					end
				end
				6: begin
					count = $urandom_range(0, 3);
					repeat (count) send_text(sextet_char(6'($urandom)), 1'b0);
					send_text(8'($urandom), 1'b1);
				end
				7: begin
					count = $urandom_range(1, 5);
					repeat (count) begin
						if ($urandom_range(0, 1) == 0) send_text("=", 1'b0);
						else send_text(sextet_char(6'($urandom)), 1'b0);
					end
					if ($urandom_range(0, 1) == 0) send_text(8'($urandom), 1'b1);
				end
				8: begin
					count = $urandom_range(1, 6);
					repeat (count) send_text(8'($urandom), 1'b0);
					if ($urandom_range(0, 1) == 0) send_text(8'($urandom), 1'b1);
				end
				default: begin
					count = $urandom_range(1, 4);
					repeat (count) send_filler();
				end
			endcase
		end
		send_text(8'($urandom), 1'b1);
		@(negedge clk);
		text_ch.valid <= 1'b0;

		// Drain, then give the decoder time to show any stray byte.
		wait (bytes_pending == 0);
		repeat (8) @(posedge clk);

		$display("Sent %0d requests (%0d flushes, %0d out-of-alphabet fillers).",
			requests_sent, flushes_sent, fillers_sent);
		$display("Checked %0d decoded bytes against the prediction.", bytes_checked);
		if (fail_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
